// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Concurrent assertion macros shared by the RTL; empty bodies under SYNTH.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Condition must hold at every clock edge out of reset.
`define AV_ASSERT(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// Same-cycle implication.
`define AV_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define AV_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define AV_ASSERT(lbl, clk, rstn, cond, msg)
`define AV_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define AV_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/av1rtp_pkg.sv =====
// ----------------------------------------------------------------------------
// av1rtp_pkg
// Shared constants and controller/datapath interface types of the AV1 OBU
// to RTP payload fragmenter.
// ----------------------------------------------------------------------------
`default_nettype none

package av1rtp_pkg;

  // Sequence header cache
  localparam int SEQ_HDR_MAX = 32;
  localparam int SEQ_IDX_W   = $clog2(SEQ_HDR_MAX);
  localparam int SEQ_CNT_W   = $clog2(SEQ_HDR_MAX + 1);

  // Register reset value
  localparam logic [15:0] MFS_RESET = 16'd1200;

  // Aggregation header fields and OBU header masks
  localparam logic [7:0] Z_BIT        = 8'h80;
  localparam logic [7:0] Y_BIT        = 8'h40;
  localparam logic [7:0] N_BIT        = 8'h08;
  localparam logic [7:0] W_ONE        = 8'h10;
  localparam logic [7:0] W_TWO        = 8'h20;
  localparam logic [7:0] TYPE_MASK    = 8'h78;
  localparam logic [7:0] LEN7_MASK    = 8'h7F;
  localparam logic [7:0] OBU_TYPE_SEQ = 8'd1;

  // Source of the next output byte
  typedef enum logic [1:0] {
    SEL_HDR,
    SEL_LEN,
    SEL_SEQ,
    SEL_DATA
  } out_sel_e;

  // Controller to datapath
  typedef struct packed {
    logic     accept;
    logic     emit;
    out_sel_e sel;
    logic     rd_adv;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic item_emit;
    logic item_open;
    logic with_seq;
    logic rep_empty;
    logic rep_last;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/av1rtp_dp.sv =====
// ----------------------------------------------------------------------------
// av1rtp_dp
// Datapath: OBU and payload counters, sequence header cache, aggregation
// header build and the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module av1rtp_dp import av1rtp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_data_i,
  // input item
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        first_of_obu_i,
  input  wire logic [15:0] obu_length_i,
  // control
  input  wire dp_cmd_t     cmd_i,
  output dp_stat_t         stat_o,
  // output item
  input  wire logic        out_stall_i,
  output logic             out_valid_o,
  output logic [7:0]       out_byte_o,
  output logic             packet_start_o,
  output logic             packet_end_o,
  output logic             last_result_o
);

  // Architectural state
  logic [15:0]          mfs_q;
  logic [SEQ_CNT_W-1:0] seq_count_q, seq_count_d;
  logic                 seq_cached_q, seq_cached_d;
  logic                 capturing_q, capturing_d;
  logic [15:0]          obu_left_q, obu_left_d;
  logic [15:0]          pay_left_q, pay_left_d;
  logic                 cont_q, cont_d;

  // Per-item latches for emission
  logic [7:0]           data_q, hdr_q, hdr_d;
  logic                 end_q;
  logic                 with_seq_q, with_seq_d;
  logic [SEQ_CNT_W-1:0] rep_cnt_q, rep_cnt_d;

  // Cache memory and replay pointer
  logic [7:0]           seq_mem [SEQ_HDR_MAX];
  logic [7:0]           rd_data_q;
  logic [SEQ_CNT_W-1:0] rd_ptr_q, rd_ptr_d;

  // Output register
  logic                 out_valid_q;
  logic [7:0]           out_byte_q;
  logic                 out_start_q, out_end_q, out_last_q;

  // Item decode
  logic                 is_seq, ignore, cap_eff, open_pl;
  logic [15:0]          obu_eff, meta, room, take, pl_eff;
  logic [SEQ_CNT_W-1:0] cnt_eff;
  logic [7:0]           obu_type;
  logic                 mem_we;

  always_comb begin
    obu_type = (data_byte_i & TYPE_MASK) >> 3;
    is_seq   = (obu_type == OBU_TYPE_SEQ);
    obu_eff  = first_of_obu_i ? obu_length_i : obu_left_q;
    if (first_of_obu_i) begin
      ignore = (obu_length_i == 16'd0) ||
               (is_seq && (obu_length_i > 16'(SEQ_HDR_MAX)));
    end else begin
      ignore = (obu_left_q == 16'd0);
    end
    cap_eff  = first_of_obu_i ? is_seq : capturing_q;
    cnt_eff  = (first_of_obu_i && is_seq) ? '0 : seq_count_q;
    open_pl  = first_of_obu_i || (pay_left_q == 16'd0);
    // payload sizing: room left after metadata, at least one OBU byte
    meta     = seq_cached_q ? (16'(seq_count_q) + 16'd2) : 16'd1;
    room     = (mfs_q > meta) ? (mfs_q - meta) : 16'd1;
    take     = (room < obu_eff) ? room : obu_eff;
    pl_eff   = open_pl ? take : pay_left_q;
  end

  // Aggregation header byte
  always_comb begin
    hdr_d = seq_cached_q ? (W_TWO | N_BIT) : W_ONE;
    if (!first_of_obu_i && cont_q) begin
      hdr_d = hdr_d | Z_BIT;
    end
    if (take < obu_eff) begin
      hdr_d = hdr_d | Y_BIT;
    end
  end

  // Next state on an accepted item
  always_comb begin
    seq_count_d  = seq_count_q;
    seq_cached_d = seq_cached_q;
    capturing_d  = capturing_q;
    obu_left_d   = obu_left_q;
    pay_left_d   = pay_left_q;
    cont_d       = cont_q;
    with_seq_d   = with_seq_q;
    rep_cnt_d    = rep_cnt_q;
    mem_we       = 1'b0;
    if (cmd_i.accept) begin
      if (first_of_obu_i) begin
        capturing_d = 1'b0;
        cont_d      = 1'b0;
        pay_left_d  = 16'd0;
        obu_left_d  = 16'd0;
        if ((obu_length_i != 16'd0) && is_seq) begin
          seq_cached_d = 1'b0;
          seq_count_d  = '0;
        end
      end
      if (!ignore) begin
        obu_left_d = obu_eff - 16'd1;
        if (cap_eff) begin
          // header capture
          mem_we      = (cnt_eff < SEQ_CNT_W'(SEQ_HDR_MAX));
          seq_count_d = cnt_eff + 1'b1;
          capturing_d = (obu_eff != 16'd1);
          if (obu_eff == 16'd1) begin
            seq_cached_d = 1'b1;
          end
        end else begin
          // payload byte
          pay_left_d = pl_eff - 16'd1;
          with_seq_d = 1'b0;
          if (open_pl) begin
            cont_d = 1'b1;
            if (seq_cached_q) begin
              with_seq_d   = 1'b1;
              rep_cnt_d    = seq_count_q;
              seq_cached_d = 1'b0;
              seq_count_d  = '0;
            end
          end
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mfs_q        <= MFS_RESET;
      seq_count_q  <= '0;
      seq_cached_q <= 1'b0;
      capturing_q  <= 1'b0;
      obu_left_q   <= 16'd0;
      pay_left_q   <= 16'd0;
      cont_q       <= 1'b0;
      with_seq_q   <= 1'b0;
      rep_cnt_q    <= '0;
      rd_ptr_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mfs_q <= cfg_data_i;
      end
      seq_count_q  <= seq_count_d;
      seq_cached_q <= seq_cached_d;
      capturing_q  <= capturing_d;
      obu_left_q   <= obu_left_d;
      pay_left_q   <= pay_left_d;
      cont_q       <= cont_d;
      with_seq_q   <= with_seq_d;
      rep_cnt_q    <= rep_cnt_d;
      rd_ptr_q     <= rd_ptr_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item payload latches
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      data_q <= data_byte_i;
      end_q  <= (pl_eff == 16'd1);
      hdr_q  <= hdr_d;
    end
  end

  // Cache memory: one write port, registered read at the replay pointer
  always_comb begin
    if (!cmd_i.rd_adv && (cmd_i.sel != SEL_SEQ)) begin
      rd_ptr_d = '0;
    end else if (cmd_i.rd_adv) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end else begin
      rd_ptr_d = rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      seq_mem[cnt_eff[SEQ_IDX_W-1:0]] <= data_byte_i;
    end
    rd_data_q <= seq_mem[rd_ptr_d[SEQ_IDX_W-1:0]];
  end

  // Output register load
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      unique case (cmd_i.sel)
        SEL_HDR: begin
          out_byte_q  <= hdr_q;
          out_start_q <= 1'b1;
          out_end_q   <= 1'b0;
          out_last_q  <= 1'b0;
        end
        SEL_LEN: begin
          out_byte_q  <= 8'(rep_cnt_q) & LEN7_MASK;
          out_start_q <= 1'b0;
          out_end_q   <= 1'b0;
          out_last_q  <= 1'b0;
        end
        SEL_SEQ: begin
          out_byte_q  <= rd_data_q;
          out_start_q <= 1'b0;
          out_end_q   <= 1'b0;
          out_last_q  <= 1'b0;
        end
        default: begin
          out_byte_q  <= data_q;
          out_start_q <= 1'b0;
          out_end_q   <= end_q;
          out_last_q  <= 1'b1;
        end
      endcase
    end
  end

  // Status to controller
  always_comb begin
    stat_o.item_emit = !ignore && !cap_eff;
    stat_o.item_open = open_pl;
    stat_o.with_seq  = with_seq_q;
    stat_o.rep_empty = (rep_cnt_q == '0);
    stat_o.rep_last  = (SEQ_CNT_W'(rd_ptr_q + 1'b1) == rep_cnt_q);
    stat_o.out_free  = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign packet_start_o = out_start_q;
  assign packet_end_o   = out_end_q;
  assign last_result_o  = out_last_q;

  // Checks
  `AV_ASSERT(a_cnt_bound, clk_i, rst_ni, seq_count_q <= SEQ_CNT_W'(SEQ_HDR_MAX), "seq count overflow")
  `AV_ASSERT(a_cache_excl, clk_i, rst_ni, !(seq_cached_q && capturing_q), "cached while capturing")
  `AV_ASSERT_IMP(a_start_not_last, clk_i, rst_ni, out_valid_q && out_start_q, !out_last_q, "header byte marked last")

endmodule

`default_nettype wire

// ===== hw/rtl/av1rtp_ctrl.sv =====
// ----------------------------------------------------------------------------
// av1rtp_ctrl
// Controller: accepts one item, then sequences the output bytes it causes
// (aggregation header, length, cached header, data byte).
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module av1rtp_ctrl import av1rtp_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HDR  = 3'd1;
  localparam logic [2:0] S_LEN  = 3'd2;
  localparam logic [2:0] S_SEQ  = 3'd3;
  localparam logic [2:0] S_DATA = 3'd4;

  logic [2:0] state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    cmd_o.accept  = 1'b0;
    cmd_o.emit    = 1'b0;
    cmd_o.sel     = SEL_DATA;
    cmd_o.rd_adv  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.accept = in_valid_i;
        if (in_valid_i && stat_i.item_emit) begin
          state_d = stat_i.item_open ? S_HDR : S_DATA;
        end
      end
      S_HDR: begin
        cmd_o.sel  = SEL_HDR;
        cmd_o.emit = stat_i.out_free;
        if (stat_i.out_free) begin
          state_d = stat_i.with_seq ? S_LEN : S_DATA;
        end
      end
      S_LEN: begin
        cmd_o.sel  = SEL_LEN;
        cmd_o.emit = stat_i.out_free;
        if (stat_i.out_free) begin
          state_d = stat_i.rep_empty ? S_DATA : S_SEQ;
        end
      end
      S_SEQ: begin
        cmd_o.sel    = SEL_SEQ;
        cmd_o.emit   = stat_i.out_free;
        cmd_o.rd_adv = stat_i.out_free;
        if (stat_i.out_free && stat_i.rep_last) begin
          state_d = S_DATA;
        end
      end
      S_DATA: begin
        cmd_o.sel  = SEL_DATA;
        cmd_o.emit = stat_i.out_free;
        if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  // Checks
  `AV_ASSERT_NXT(a_emit_leaves_idle, clk_i, rst_ni, cmd_o.accept && stat_i.item_emit, state_q != S_IDLE, "emitting item left controller idle")
  `AV_ASSERT_NXT(a_data_ends_item, clk_i, rst_ni, (state_q == S_DATA) && cmd_o.emit, state_q == S_IDLE, "data byte did not end item")
  `AV_ASSERT_IMP(a_replay_only_seq, clk_i, rst_ni, state_q == S_SEQ, stat_i.with_seq, "replay without cached header")

endmodule

`default_nettype wire

// ===== hw/rtl/av1_obu_rtp_fragmenter.sv =====
// ----------------------------------------------------------------------------
// av1_obu_rtp_fragmenter
// AV1 OBU to RTP payload fragmenter with sequence header caching.
// ----------------------------------------------------------------------------
// Takes one OBU byte per transaction and emits RTP payload bytes, each
// payload opened by a Z|Y|W|N aggregation header. Sequence header OBUs (up to
// SEQ_HDR_MAX bytes) are cached and replayed, with a length byte, in the next
// payload that opens. A byte that produces no output (header capture, stray
// or ignored byte) is simply accepted. A data byte that opens a payload is
// preceded by the aggregation header and, on replay, the length byte and the
// cached header bytes. The controller moves one output byte per cycle while
// the output is not stalled, through a single output register, and holds off
// the input while an item's bytes drain. The user must write max_fragment_size
// through the configuration port only while the block is idle; the block does
// not enforce this. The cache needs no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module av1_obu_rtp_fragmenter import av1rtp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i,
  // input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        first_of_obu_i,
  input  wire logic [15:0] obu_length_i,
  // output channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             packet_start_o,
  output logic             packet_end_o,
  output logic             last_result_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  av1rtp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  av1rtp_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .data_byte_i    (data_byte_i),
    .first_of_obu_i (first_of_obu_i),
    .obu_length_i   (obu_length_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .out_byte_o     (out_byte_o),
    .packet_start_o (packet_start_o),
    .packet_end_o   (packet_end_o),
    .last_result_o  (last_result_o)
  );

endmodule

`default_nettype wire
